[sv/i2cee_pkg.sv]
package i2cee_pkg;

    localparam int DEV_ADDR_W = 7;
    localparam int BYTE_W     = 8;
    localparam int ERR_W      = 3;

    // Read/write bit appended to the device address
    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    // Nine clocked bits per byte: eight data bits and the acknowledge
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [3:0] BITS_WITH_ACK = 4'd9;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_BEGIN_WR   = 2'd1,
        OP_BEGIN_RD   = 2'd2,
        OP_WRITE_BYTE = 2'd3
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 3'd0,
        ERR_DEV_NACK   = 3'd1,
        ERR_ADDR_NACK  = 3'd2,
        ERR_DATA_NACK  = 3'd3,
        ERR_RADDR_NACK = 3'd4
    } t_err;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START     = 4'd1,
        PH_SEND_DEV  = 4'd2,
        PH_SEND_ADDR = 4'd3,
        PH_WAIT_DATA = 4'd4,
        PH_SEND_DATA = 4'd5,
        PH_RESTART   = 4'd6,
        PH_SEND_RDEV = 4'd7,
        PH_RECV      = 4'd8,
        PH_STOP      = 4'd9
    } t_phase;

    typedef struct packed {
        logic [1:0]        operation;
        logic [BYTE_W-1:0] word_address;
        logic [BYTE_W-1:0] transfer_length;
        logic [BYTE_W-1:0] data_byte;
        logic              sda_in;
    } t_in_item;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_driving;
        logic [BYTE_W-1:0] read_data;
        logic              read_valid;
        logic              data_request;
        logic              busy_res;
        logic              done_res;
        logic [ERR_W-1:0]  error_code;
    } t_out_item;

endpackage

[sv/i2cee_in_if.sv]
interface i2cee_in_if;
    import i2cee_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/i2cee_out_if.sv]
interface i2cee_out_if;
    import i2cee_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/i2c_eeprom_transaction_master.sv]
// I2C master for one serial EEPROM transaction: a page write, or a random or
// sequential read.
// Input channel i_in: each beat is a command. A begin-write or begin-read beat
// latches word address and byte count; a tick beat is one half-bit time and
// carries the sampled SDA level; a write-byte beat supplies the next data byte
// while data_request is high. Beats that do not fit the current phase change
// nothing but still yield a result beat.
// Output channel o_out: exactly one result beat per input beat, carrying the
// SCL/SDA levels to drive, read data, request, busy, done and error status.
// The result of a beat is registered and valid in the cycle after it is accepted.
// Throughput: one beat per cycle while o_out does not stall; the whole step
// is one pass of the phase logic into the result register.
// i_cfg_we/i_cfg_data load the seven-bit device address; write it only while
// no transaction runs.
// Reset (synchronous, active low): idle phase, SCL high, SDA released, device
// address 80, result register empty.
// When o_out stalls, the result register holds its beat and i_in is taken
// only in the cycle the held beat leaves, so no beat is lost or repeated.
module i2c_eeprom_transaction_master (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    i2cee_in_if.sink                            i_in,
    i2cee_out_if.source                         o_out,
    input  logic                                i_cfg_we,
    input  logic [i2cee_pkg::DEV_ADDR_W-1:0]    i_cfg_data
);
    import i2cee_pkg::*;

    t_phase                r_phase,    n_phase;
    logic                  r_half,     n_half;
    logic [3:0]            r_bitcnt,   n_bitcnt;
    logic [BYTE_W-1:0]     r_shift,    n_shift;
    logic [BYTE_W-1:0]     r_remain,   n_remain;
    logic                  r_read_dir, n_read_dir;
    logic [BYTE_W-1:0]     r_addr,     n_addr;
    logic [ERR_W-1:0]      r_abort,    n_abort;
    logic                  r_scl,      n_scl;
    logic                  r_sda,      n_sda;
    logic                  r_drive,    n_drive;
    logic [DEV_ADDR_W-1:0] r_dev_addr;
    logic                  r_out_valid;
    t_out_item             r_out,      n_out;

    logic                  in_fire;
    logic                  tick;
    logic [1:0]            op;
    logic [BYTE_W-1:0]     remain_dec;
    logic [BYTE_W-1:0]     shift_in;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign op          = i_in.data.operation;
    assign tick        = (op == OP_TICK);
    assign remain_dec  = r_remain - BYTE_W'(1);
    assign shift_in    = {r_shift[BYTE_W-2:0], i_in.data.sda_in};

    // Next state of the bus sequencer
    always_comb begin
        n_phase    = r_phase;
        n_half     = r_half;
        n_bitcnt   = r_bitcnt;
        n_shift    = r_shift;
        n_remain   = r_remain;
        n_read_dir = r_read_dir;
        n_addr     = r_addr;
        n_abort    = r_abort;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_drive    = r_drive;
        case (r_phase)
            PH_IDLE: begin
                if (op == OP_BEGIN_WR || op == OP_BEGIN_RD) begin
                    n_read_dir = (op == OP_BEGIN_RD);
                    n_addr     = i_in.data.word_address;
                    n_remain   = i_in.data.transfer_length;
                    n_abort    = ERR_OK;
                    n_half     = 1'b0;
                    n_bitcnt   = '0;
                    n_scl      = 1'b1;
                    n_sda      = 1'b1;
                    n_drive    = 1'b1;
                    n_phase    = PH_START;
                end
            end
            PH_START: begin
                if (tick) begin
                    n_sda    = 1'b0;
                    n_shift  = {r_dev_addr, RW_WRITE};
                    n_phase  = PH_SEND_DEV;
                    n_bitcnt = '0;
                    n_half   = 1'b0;
                end
            end
            PH_RESTART: begin
                if (tick) begin
                    if (!r_half) begin
                        n_scl  = 1'b1;
                        n_half = 1'b1;
                    end else begin
                        n_sda    = 1'b0;
                        n_shift  = {r_dev_addr, RW_READ};
                        n_phase  = PH_SEND_RDEV;
                        n_bitcnt = '0;
                        n_half   = 1'b0;
                    end
                end
            end
            PH_SEND_DEV, PH_SEND_ADDR, PH_SEND_DATA, PH_SEND_RDEV: begin
                if (tick) begin
                    if (r_bitcnt >= BITS_WITH_ACK) begin
                        n_half   = 1'b0;
                        n_bitcnt = '0;
                        n_scl    = 1'b0;
                        if (i_in.data.sda_in) begin
                            // no acknowledge: abort through STOP
                            case (r_phase)
                                PH_SEND_DEV:  n_abort = ERR_DEV_NACK;
                                PH_SEND_ADDR: n_abort = ERR_ADDR_NACK;
                                PH_SEND_DATA: n_abort = ERR_DATA_NACK;
                                default:      n_abort = ERR_RADDR_NACK;
                            endcase
                            n_phase = PH_STOP;
                            n_sda   = 1'b0;
                            n_drive = 1'b1;
                        end else begin
                            case (r_phase)
                                PH_SEND_DEV: begin
                                    n_shift = r_addr;
                                    n_phase = PH_SEND_ADDR;
                                    n_sda   = r_addr[BYTE_W-1];
                                    n_drive = 1'b1;
                                    n_half  = 1'b1;
                                end
                                PH_SEND_ADDR: begin
                                    if (r_read_dir) begin
                                        n_phase = PH_RESTART;
                                        n_sda   = 1'b1;
                                        n_drive = 1'b1;
                                    end else begin
                                        n_phase = (r_remain != '0) ? PH_WAIT_DATA : PH_STOP;
                                        n_sda   = 1'b0;
                                        n_drive = 1'b1;
                                    end
                                end
                                PH_SEND_DATA: begin
                                    n_remain = remain_dec;
                                    n_phase  = (remain_dec != '0) ? PH_WAIT_DATA : PH_STOP;
                                    n_sda    = 1'b0;
                                    n_drive  = 1'b1;
                                end
                                default: begin
                                    if (r_remain != '0) begin
                                        n_phase = PH_RECV;
                                        n_half  = 1'b1;
                                        n_sda   = 1'b1;
                                        n_drive = 1'b0;
                                    end else begin
                                        n_phase = PH_STOP;
                                        n_sda   = 1'b0;
                                        n_drive = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end else if (!r_half) begin
                        // SCL low half: present the next bit or release for ACK
                        n_scl  = 1'b0;
                        n_half = 1'b1;
                        if (r_bitcnt < BITS_PER_BYTE) begin
                            n_sda   = r_shift[~r_bitcnt[2:0]];
                            n_drive = 1'b1;
                        end else begin
                            n_sda   = 1'b1;
                            n_drive = 1'b0;
                        end
                    end else begin
                        n_scl    = 1'b1;
                        n_half   = 1'b0;
                        n_bitcnt = r_bitcnt + 4'd1;
                    end
                end
            end
            PH_WAIT_DATA: begin
                if (op == OP_WRITE_BYTE) begin
                    n_shift  = i_in.data.data_byte;
                    n_phase  = PH_SEND_DATA;
                    n_bitcnt = '0;
                    n_scl    = 1'b0;
                    n_sda    = i_in.data.data_byte[BYTE_W-1];
                    n_drive  = 1'b1;
                    n_half   = 1'b1;
                end
            end
            PH_RECV: begin
                if (tick) begin
                    if (r_bitcnt >= BITS_WITH_ACK) begin
                        n_remain = remain_dec;
                        n_bitcnt = '0;
                        n_scl    = 1'b0;
                        if (remain_dec != '0) begin
                            n_half  = 1'b1;
                            n_sda   = 1'b1;
                            n_drive = 1'b0;
                        end else begin
                            n_phase = PH_STOP;
                            n_half  = 1'b0;
                            n_sda   = 1'b0;
                            n_drive = 1'b1;
                        end
                    end else if (!r_half) begin
                        if (r_bitcnt >= 4'd1) begin
                            n_shift = shift_in;
                        end
                        n_scl  = 1'b0;
                        n_half = 1'b1;
                        if (r_bitcnt >= BITS_PER_BYTE) begin
                            // ACK all but the last byte
                            n_drive = 1'b1;
                            n_sda   = (r_remain <= BYTE_W'(1));
                        end else begin
                            n_drive = 1'b0;
                            n_sda   = 1'b1;
                        end
                    end else begin
                        n_scl    = 1'b1;
                        n_half   = 1'b0;
                        n_bitcnt = r_bitcnt + 4'd1;
                    end
                end
            end
            PH_STOP: begin
                if (tick) begin
                    if (!r_half) begin
                        n_scl  = 1'b1;
                        n_half = 1'b1;
                    end else begin
                        n_sda    = 1'b1;
                        n_drive  = 1'b0;
                        n_phase  = PH_IDLE;
                        n_half   = 1'b0;
                        n_bitcnt = '0;
                    end
                end
            end
            default: begin
                n_phase    = PH_IDLE;
                n_half     = 1'b0;
                n_bitcnt   = '0;
                n_shift    = '0;
                n_remain   = '0;
                n_read_dir = 1'b0;
                n_addr     = '0;
                n_abort    = ERR_OK;
                n_scl      = 1'b1;
                n_sda      = 1'b1;
                n_drive    = 1'b0;
            end
        endcase
    end

    // Result beat for the current step
    always_comb begin
        n_out              = '0;
        n_out.scl_level    = n_scl;
        n_out.sda_level    = n_sda;
        n_out.sda_driving  = n_drive;
        n_out.data_request = (n_phase == PH_WAIT_DATA);
        n_out.busy_res     = (n_phase != PH_IDLE);
        case (r_phase)
            PH_RECV: begin
                if (tick && r_bitcnt < BITS_WITH_ACK && !r_half
                        && r_bitcnt >= BITS_PER_BYTE) begin
                    n_out.read_valid = 1'b1;
                    n_out.read_data  = n_shift;
                end
            end
            PH_STOP: begin
                if (tick && r_half) begin
                    n_out.done_res   = 1'b1;
                    n_out.error_code = r_abort;
                end
            end
            default: begin
                n_out.read_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_half     <= 1'b0;
            r_bitcnt   <= '0;
            r_shift    <= '0;
            r_remain   <= '0;
            r_read_dir <= 1'b0;
            r_addr     <= '0;
            r_abort    <= ERR_OK;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
            r_drive    <= 1'b0;
        end else if (in_fire) begin
            r_phase    <= n_phase;
            r_half     <= n_half;
            r_bitcnt   <= n_bitcnt;
            r_shift    <= n_shift;
            r_remain   <= n_remain;
            r_read_dir <= n_read_dir;
            r_addr     <= n_addr;
            r_abort    <= n_abort;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
            r_drive    <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_W'(80);
        end else if (i_cfg_we) begin
            r_dev_addr <= i_cfg_data;
        end
    end

    // Output register: load on an accepted beat, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_bitcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bitcnt <= BITS_WITH_ACK)
        else $error("bit counter beyond acknowledge bit");

    a_idle_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_scl && r_sda && !r_drive)
        else $error("bus not released while idle");

    a_wait_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_WAIT_DATA |-> !r_scl && !r_sda && r_drive)
        else $error("bus not held low while waiting for data");

    a_rvalid_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.read_valid |-> r_phase == PH_RECV)
        else $error("read byte reported outside receive phase");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |=> $stable(r_phase) && $stable(r_bitcnt))
        else $error("sequencer advanced while input stalled");

endmodule
